/* rtl/core/lpt_pkg.sv */
// lpt_pkg: types, constants and transition table of the log pattern tokenizer
// no dependencies; imported by log_pattern_tokenizer
package lpt_pkg;

  localparam int MAX_PATTERN_LEN = 256;
  localparam int POS_W           = $clog2(MAX_PATTERN_LEN + 1);
  localparam int SPAN_W          = 8;
  localparam int SEG_END_W       = 9;
  localparam int CHAR_W          = 8;
  localparam int KIND_W          = 3;
  localparam int S_TDATA_W       = 8;
  localparam int M_TDATA_W       = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;

  typedef enum logic [11:0] {
    ST_START          = 12'b0000_0000_0001,
    ST_TEXT_BEGIN     = 12'b0000_0000_0010,
    ST_TEXT_KEEP      = 12'b0000_0000_0100,
    ST_PCT_AFTER_TEXT = 12'b0000_0000_1000,
    ST_SINGLE_PCT     = 12'b0000_0001_0000,
    ST_SPEC           = 12'b0000_0010_0000,
    ST_DOUBLE_PCT     = 12'b0000_0100_0000,
    ST_WAIT_BRACE     = 12'b0000_1000_0000,
    ST_TF_BEGIN       = 12'b0001_0000_0000,
    ST_TF_KEEP        = 12'b0010_0000_0000,
    ST_TF_END         = 12'b0100_0000_0000,
    ST_INVALID        = 12'b1000_0000_0000
  } parse_state_t;

  typedef enum logic [2:0] {
    CL_PCT   = 3'd0,
    CL_D     = 3'd1,
    CL_OPEN  = 3'd2,
    CL_CLOSE = 3'd3,
    CL_OTHER = 3'd4
  } char_class_t;

  typedef enum logic [KIND_W-1:0] {
    TK_TEXT    = 3'd0,
    TK_SPEC    = 3'd1,
    TK_UNKNOWN = 3'd2,
    TK_PERCENT = 3'd3,
    TK_TIME    = 3'd4,
    TK_ERROR   = 3'd5,
    TK_DONE    = 3'd6
  } token_kind_t;

  typedef struct packed {
    token_kind_t              kind;
    logic [SPAN_W-1:0]        seg_begin;
    logic [SEG_END_W-1:0]     seg_end;
    logic [CHAR_W-1:0]        spec_char;
    logic                     run_last;
  } token_t;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t cl;
    case (c)
      CH_PCT:   cl = CL_PCT;
      CH_D:     cl = CL_D;
      CH_OPEN:  cl = CL_OPEN;
      CH_CLOSE: cl = CL_CLOSE;
      default:  cl = CL_OTHER;
    endcase
    return cl;
  endfunction

  function automatic logic known_spec(input logic [CHAR_W-1:0] c);
    return c inside {8'h6D, 8'h63, 8'h4C, 8'h6C, 8'h74, 8'h6E, 8'h66, 8'h54, 8'h52};
  endfunction

  function automatic parse_state_t next_state(input parse_state_t st, input char_class_t cl);
    parse_state_t ns;
    case (st)
      ST_START, ST_SPEC, ST_DOUBLE_PCT, ST_TF_END: begin
        ns = (cl == CL_PCT) ? ST_SINGLE_PCT : ST_TEXT_BEGIN;
      end
      ST_TEXT_BEGIN, ST_TEXT_KEEP: begin
        ns = (cl == CL_PCT) ? ST_PCT_AFTER_TEXT : ST_TEXT_KEEP;
      end
      ST_PCT_AFTER_TEXT, ST_SINGLE_PCT: begin
        case (cl)
          CL_PCT:   ns = ST_DOUBLE_PCT;
          CL_D:     ns = ST_WAIT_BRACE;
          CL_OTHER: ns = ST_SPEC;
          default:  ns = ST_INVALID;
        endcase
      end
      ST_WAIT_BRACE: begin
        ns = (cl == CL_OPEN) ? ST_TF_BEGIN : ST_INVALID;
      end
      ST_TF_BEGIN, ST_TF_KEEP: begin
        ns = (cl == CL_CLOSE) ? ST_TF_END : ST_TF_KEEP;
      end
      default: ns = ST_INVALID;
    endcase
    return ns;
  endfunction

endpackage

/* rtl/core/log_pattern_tokenizer.sv */
// log_pattern_tokenizer: splits a log format pattern, one byte per transfer, into tokens
// depends on lpt_pkg
//
//   channel  dir  tdata                                      tuser       tlast
//   s_*      in   [7:0] ch                                   -           final_char
//   m_*      out  [7:0] seg_begin [16:8] seg_end [24:17]     [2:0] kind  run_last
//                 spec_char, rest zero
//
// one input byte per cycle while s_tready is high; each byte yields zero, one or
// two tokens, computed in the cycle it is taken and held in a four-entry output queue
// the queue drains one token per cycle while m_tready is high; s_tready stays high
// while at least two queue entries are free
// rst is synchronous and clears the parse state, position and queue
module log_pattern_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lpt_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] ch
  input  logic                              s_tlast,   // final_char
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lpt_pkg::M_TDATA_W-1:0]     m_tdata,   // seg_begin, seg_end, spec_char
  output logic [lpt_pkg::KIND_W-1:0]        m_tuser,   // token_kind
  output logic                              m_tlast    // run_last
);
  import lpt_pkg::*;

  parse_state_t          parse_state, parse_state_next;
  logic [POS_W-1:0]      char_position, char_position_next;
  logic [SPAN_W-1:0]     span_start, span_start_next;

  token_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_count;

  logic                  in_xfer, out_xfer;
  logic [CHAR_W-1:0]     c;
  logic                  fin;
  logic                  step_valid, fin_valid;
  token_t                step_tok, fin_tok, tok0, tok1;
  parse_state_t          st_mid;
  logic [SPAN_W-1:0]     span_mid;
  logic [POS_W:0]        pos_inc;
  logic [1:0]            push_n;

  assign c        = s_tdata[CHAR_W-1:0];
  assign fin      = s_tlast;
  assign s_tready = (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign pos_inc  = {1'b0, char_position} + 1'b1;

  always_comb begin
    st_mid     = parse_state;
    span_mid   = span_start;
    step_valid = 1'b0;
    step_tok   = '{kind: TK_DONE, seg_begin: '0, seg_end: '0, spec_char: '0, run_last: 1'b0};
    if (parse_state == ST_INVALID) begin
      st_mid = ST_INVALID;
    end else if (char_position >= POS_W'(MAX_PATTERN_LEN)) begin
      st_mid        = ST_INVALID;
      step_valid    = 1'b1;
      step_tok.kind = TK_ERROR;
    end else begin
      st_mid = next_state(parse_state, classify(c));
      case (st_mid)
        ST_TEXT_BEGIN, ST_TF_BEGIN: begin
          span_mid = SPAN_W'(char_position);
        end
        ST_PCT_AFTER_TEXT: begin
          step_valid         = 1'b1;
          step_tok.kind      = TK_TEXT;
          step_tok.seg_begin = span_start;
          step_tok.seg_end   = SEG_END_W'(char_position);
          span_mid           = '0;
        end
        ST_SPEC: begin
          step_valid         = 1'b1;
          step_tok.kind      = known_spec(c) ? TK_SPEC : TK_UNKNOWN;
          step_tok.spec_char = c;
        end
        ST_DOUBLE_PCT: begin
          step_valid    = 1'b1;
          step_tok.kind = TK_PERCENT;
        end
        ST_TF_END: begin
          step_valid         = 1'b1;
          step_tok.kind      = TK_TIME;
          step_tok.seg_begin = span_start + 1'b1;
          step_tok.seg_end   = SEG_END_W'(char_position);
          span_mid           = '0;
        end
        ST_INVALID: begin
          step_valid    = 1'b1;
          step_tok.kind = TK_ERROR;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fin_valid = fin;
    fin_tok   = '{kind: TK_DONE, seg_begin: '0, seg_end: '0, spec_char: '0, run_last: 1'b1};
    case (st_mid)
      ST_TEXT_BEGIN, ST_TEXT_KEEP: begin
        fin_tok.kind      = TK_TEXT;
        fin_tok.seg_begin = span_mid;
        fin_tok.seg_end   = SEG_END_W'(pos_inc);
      end
      ST_PCT_AFTER_TEXT, ST_SINGLE_PCT, ST_WAIT_BRACE, ST_TF_BEGIN, ST_TF_KEEP: begin
        fin_tok.kind = TK_ERROR;
      end
      default: ;
    endcase
    if (step_valid) begin
      tok0          = step_tok;
      tok0.run_last = !fin_valid;
    end else begin
      tok0 = fin_tok;
    end
    tok1   = fin_tok;
    push_n = in_xfer ? (2'(step_valid) + 2'(fin_valid)) : 2'd0;
  end

  always_comb begin
    parse_state_next   = st_mid;
    span_start_next    = span_mid;
    char_position_next = char_position;
    if (fin) begin
      parse_state_next   = ST_START;
      span_start_next    = '0;
      char_position_next = '0;
    end else if (char_position < POS_W'(MAX_PATTERN_LEN)) begin
      char_position_next = pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= ST_START;
      char_position <= '0;
      span_start    <= '0;
    end else if (in_xfer) begin
      parse_state   <= parse_state_next;
      char_position <= char_position_next;
      span_start    <= span_start_next;
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= tok0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + 1'b1] <= tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_PTR_W'(push_n);
      rd_ptr     <= rd_ptr + FIFO_PTR_W'(out_xfer);
      fifo_count <= fifo_count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(out_xfer);
    end
  end

  assign m_tvalid = (fifo_count != '0);
  assign m_tuser  = fifo_mem[rd_ptr].kind;
  assign m_tlast  = fifo_mem[rd_ptr].run_last;
  assign m_tdata  = {{(M_TDATA_W - SPAN_W - SEG_END_W - CHAR_W){1'b0}},
                     fifo_mem[rd_ptr].spec_char,
                     fifo_mem[rd_ptr].seg_end,
                     fifo_mem[rd_ptr].seg_begin};

endmodule
